// ===== rtl/fwisr_pkg.sv =====
// Shared constants, types and request/status codes for the keyed search-and-remove queue.
package fwisr_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int ID_BITS     = 16;
	localparam int HANDLE_W    = 32;
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int IDX_W       = $clog2(QUEUE_DEPTH);

	typedef logic [HANDLE_W-1:0] handle_t;
	typedef logic [ID_BITS-1:0]  id_t;
	typedef logic [CNT_W-1:0]    cnt_t;
	typedef logic [IDX_W-1:0]    idx_t;

	typedef enum logic [1:0] {
		REQ_PUT    = 2'd0,
		REQ_GET    = 2'd1,
		REQ_SEARCH = 2'd2,
		REQ_REMOVE = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_EMPTY     = 2'd1,
		STAT_FULL      = 2'd2,
		STAT_NOT_FOUND = 2'd3
	} stat_t;

	typedef struct packed {
		logic shift;
		logic load;
	} cell_ctrl_t;

endpackage

// ===== rtl/fwisr_cell.sv =====
// One queue slot: holds a handle and an id, loads new data or takes its upper neighbor's.
module fwisr_cell (
	input  logic                 clk,
	input  fwisr_pkg::cell_ctrl_t ctrl,
	input  fwisr_pkg::handle_t   ld_handle,
	input  fwisr_pkg::id_t       ld_id,
	input  fwisr_pkg::handle_t   nbr_handle,
	input  fwisr_pkg::id_t       nbr_id,
	output fwisr_pkg::handle_t   handle,
	output fwisr_pkg::id_t       id
);
	import fwisr_pkg::*;

	handle_t handle_q;
	id_t     id_q;

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			handle_q <= ld_handle;
			id_q     <= ld_id;
		end else if (ctrl.shift) begin
			handle_q <= nbr_handle;
			id_q     <= nbr_id;
		end
	end

	assign handle = handle_q;
	assign id     = id_q;

endmodule

// ===== rtl/fifo_with_id_search_remove_core.sv =====
// Top level: queue control and the chain of slot cells, head at cell zero.
//
//  channel | dir | tdata (low bit up)                                   | tuser
//  s_*     | in  | entry_handle, thread_id, key_id                      | req_type
//  m_*     | out | result_handle, removed_count, entry_count, is_empty  | status
//
// A put or get registers its result from S_EXEC once the output is free; a search or remove
// walks the chain once, rotating each head entry to the tail (a remove drops matches), and
// then finishes. s_tready rises again with the result.
// One request is worked at a time; a new one is taken while the previous result waits.
// A result held by m_tready low stalls completion of the next request, not its acceptance.
// arst_n clears occupancy and control; slot contents are left as they are.
module fifo_with_id_search_remove_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,  // entry_handle[31:0], thread_id[47:32], key_id[63:48]
	input  logic [1:0]  s_tuser,  // req_type[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,  // result_handle[31:0], removed_count[36:32],
	                              // entry_count[41:37], is_empty[42], zero[47:43]
	output logic [1:0]  m_tuser   // status[1:0]
);
	import fwisr_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} state_t;

	state_t  state_q;
	req_t    req_q;
	handle_t handle_q;
	id_t     tid_q;
	id_t     key_q;
	cnt_t    cnt_q;
	cnt_t    steps_q;
	cnt_t    removed_q;
	logic    found_q;
	handle_t hit_q;

	logic        m_tvalid_q;
	stat_t       stat_out_q;
	handle_t     rh_out_q;
	logic [4:0]  rem_out_q;
	logic [4:0]  cnt_out_q;
	logic        empty_out_q;

	handle_t    cell_h  [QUEUE_DEPTH];
	id_t        cell_id [QUEUE_DEPTH];
	cell_ctrl_t cell_ctrl [QUEUE_DEPTH];

	logic    accept;
	logic    out_free;
	logic    head_match;
	logic    shift;
	logic    load_en;
	idx_t    load_idx;
	handle_t ld_handle;
	id_t     ld_id;
	cnt_t    cnt_d;
	logic    finish;
	stat_t   stat_d;
	handle_t rh_d;

	assign s_tready   = (state_q == S_IDLE);
	assign accept     = s_tvalid && s_tready;
	assign out_free   = !m_tvalid_q || m_tready;
	assign head_match = (cell_id[0] == key_q);

	always_comb begin
		shift     = 1'b0;
		load_en   = 1'b0;
		load_idx  = '0;
		ld_handle = handle_q;
		ld_id     = tid_q;
		cnt_d     = cnt_q;
		finish    = 1'b0;
		stat_d    = STAT_OK;
		rh_d      = '0;
		if (state_q == S_EXEC) begin
			unique case (req_q)
				REQ_PUT: begin
					if (out_free) begin
						finish = 1'b1;
						if (cnt_q < CNT_W'(QUEUE_DEPTH)) begin
							load_en  = 1'b1;
							load_idx = cnt_q[IDX_W-1:0];
							cnt_d    = cnt_q + CNT_W'(1);
						end else begin
							stat_d = STAT_FULL;
						end
					end
				end
				REQ_GET: begin
					if (out_free) begin
						finish = 1'b1;
						if (cnt_q == '0) begin
							stat_d = STAT_EMPTY;
						end else begin
							shift = 1'b1;
							rh_d  = cell_h[0];
							cnt_d = cnt_q - CNT_W'(1);
						end
					end
				end
				REQ_SEARCH: begin
					if (steps_q != '0) begin
						shift     = 1'b1;
						load_en   = 1'b1;
						load_idx  = IDX_W'(cnt_q - CNT_W'(1));
						ld_handle = cell_h[0];
						ld_id     = cell_id[0];
					end else if (out_free) begin
						finish = 1'b1;
						stat_d = found_q ? STAT_OK : STAT_NOT_FOUND;
						rh_d   = found_q ? hit_q : '0;
					end
				end
				REQ_REMOVE: begin
					if (steps_q != '0) begin
						shift = 1'b1;
						if (head_match) begin
							cnt_d = cnt_q - CNT_W'(1);
						end else begin
							load_en   = 1'b1;
							load_idx  = IDX_W'(cnt_q - CNT_W'(1));
							ld_handle = cell_h[0];
							ld_id     = cell_id[0];
						end
					end else if (out_free) begin
						finish = 1'b1;
						stat_d = (removed_q != '0) ? STAT_OK : STAT_NOT_FOUND;
					end
				end
				default: begin
					finish = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cnt_q      <= '0;
			steps_q    <= '0;
			removed_q  <= '0;
			found_q    <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			cnt_q <= cnt_d;
			if (accept) begin
				state_q   <= S_EXEC;
				steps_q   <= (req_t'(s_tuser) == REQ_SEARCH || req_t'(s_tuser) == REQ_REMOVE)
				             ? cnt_q : '0;
				removed_q <= '0;
				found_q   <= 1'b0;
			end else if (state_q == S_EXEC && steps_q != '0) begin
				steps_q <= steps_q - CNT_W'(1);
				if (req_q == REQ_REMOVE && head_match) begin
					removed_q <= removed_q + CNT_W'(1);
				end
				if (req_q == REQ_SEARCH && head_match && !found_q) begin
					found_q <= 1'b1;
				end
			end else if (finish) begin
				state_q <= S_IDLE;
			end
			if (finish) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q    <= req_t'(s_tuser);
			handle_q <= s_tdata[31:0];
			tid_q    <= id_t'(s_tdata[47:32]);
			key_q    <= id_t'(s_tdata[63:48]);
		end
		if (state_q == S_EXEC && req_q == REQ_SEARCH && steps_q != '0 && head_match
		    && !found_q) begin
			hit_q <= cell_h[0];
		end
		if (finish) begin
			stat_out_q  <= stat_d;
			rh_out_q    <= rh_d;
			rem_out_q   <= 5'(removed_q);
			cnt_out_q   <= 5'(cnt_d);
			empty_out_q <= (cnt_d == '0);
		end
	end

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		assign cell_ctrl[i].shift = shift;
		assign cell_ctrl[i].load  = load_en && (load_idx == IDX_W'(i));
		if (i == QUEUE_DEPTH - 1) begin : g_last
			fwisr_cell u_cell (
				.clk        (clk),
				.ctrl       (cell_ctrl[i]),
				.ld_handle  (ld_handle),
				.ld_id      (ld_id),
				.nbr_handle (cell_h[i]),
				.nbr_id     (cell_id[i]),
				.handle     (cell_h[i]),
				.id         (cell_id[i])
			);
		end else begin : g_mid
			fwisr_cell u_cell (
				.clk        (clk),
				.ctrl       (cell_ctrl[i]),
				.ld_handle  (ld_handle),
				.ld_id      (ld_id),
				.nbr_handle (cell_h[i+1]),
				.nbr_id     (cell_id[i+1]),
				.handle     (cell_h[i]),
				.id         (cell_id[i])
			);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = stat_out_q;
	assign m_tdata  = {5'd0, empty_out_q, cnt_out_q, rem_out_q, rh_out_q};

endmodule
